// ----- rtl/scap_pkg.sv -----
// Shared constants for the scope capture and trigger block.
// Register indexes, field widths, register reset values and input beat kinds.
// No dependencies.
`default_nettype none

package scap_pkg;

	// Fixed field widths
	localparam int SMP_W      = 16;  // Q4.11 voltage
	localparam int TICK_W     = 20;  // tick counter and holdoff
	localparam int FRAME_W    = 16;  // frame_count
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 20;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_COUNT = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HOLDOFF     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LISSAJOUS   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_TRIG_HIGH   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_TRIG_LOW    = 3'd4;

	// Register reset values
	localparam logic [FRAME_W-1:0]      FRAME_COUNT_RST = 16'd3;
	localparam logic [TICK_W-1:0]       HOLDOFF_RST     = 20'd4410;
	localparam logic                    LISSAJOUS_RST   = 1'b1;
	localparam logic signed [SMP_W-1:0] TRIG_HIGH_RST   = 16'sd2048;
	localparam logic signed [SMP_W-1:0] TRIG_LOW_RST    = 16'sd0;

	// Input beat kinds (carried on tuser)
	localparam logic ACT_TICK = 1'b0;
	localparam logic ACT_READ = 1'b1;

endpackage

`default_nettype wire

// ----- rtl/scap_ram.sv -----
// Generic simple dual-port RAM: one write port, one registered read port.
// Used for the X/Y capture store. No dependencies.
`default_nettype none

module scap_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 512,
	localparam int ADDR_W = $clog2(DEPTH)
) (
	input  wire              clk,
	input  wire              we,
	input  wire [ADDR_W-1:0] waddr,
	input  wire [WIDTH-1:0]  wdata,
	input  wire              re,
	input  wire [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port and registered read; rdata holds while re is low
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

// ----- rtl/scope_capture_trigger.sv -----
// Scope capture engine: decimated X/Y capture into a RAM, Schmitt trigger,
// holdoff re-arm, external mode button and store readback.
// Depends on scap_pkg and scap_ram.
//
//  channel  | direction | beat contents
//  ---------+-----------+-----------------------------------------------------
//  s_*      | in        | tuser: action; tdata: x, y, trigger, connected, button,
//           |           | read index
//  m_*      | out       | tdata: read x, read y, fill position, ext mode, waiting
//  cfg_*    | in        | register index and write data, always ready
//
// One beat is accepted per cycle while s_tready is high. All scalar state (fill
// index, tick counter, Schmitt flags, mode) updates when a tick beat is accepted;
// the store is written then, or read via the registered RAM port into stage 1,
// then the output register. A read never shares a cycle with a write, and a
// write is complete before the next beat's read is issued. Reset clears control
// state only; the store content is undefined until written. A stalled output
// holds the two-stage pipe and deasserts s_tready only once both stages are full.
`default_nettype none

module scope_capture_trigger #(
	parameter int CAPTURE_DEPTH = 512,
	parameter int SAMPLE_BITS   = 16,
	localparam int IDX_W  = $clog2(CAPTURE_DEPTH),
	localparam int FILL_W = IDX_W + 1,
	localparam int S_DATA_W = ((3 * 16 + 2 + IDX_W + 7) / 8) * 8,
	localparam int M_DATA_W = ((2 * 16 + FILL_W + 2 + 7) / 8) * 8
) (
	input  wire                 clk,
	input  wire                 arst_n,
	// input stream
	input  wire                 s_tvalid,
	output logic                s_tready,
	input  wire                 s_tuser,   // [0] action
	// [15:0] sample_x, [31:16] sample_y, [47:32] trigger_in,
	// [48] trigger_connected, [49] external_button, [49+IDX_W:50] read_index
	input  wire [S_DATA_W-1:0]  s_tdata,
	// result stream
	output logic                m_tvalid,
	input  wire                 m_tready,
	// [15:0] read_x, [31:16] read_y, [31+FILL_W:32] fill_position,
	// [32+FILL_W] external_active, [33+FILL_W] waiting_trigger
	output logic [M_DATA_W-1:0] m_tdata,
	// configuration writes
	input  wire                 cfg_valid,
	output logic                cfg_ready,
	input  wire [scap_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire [scap_pkg::CFG_DATA_W-1:0] cfg_data
);

	import scap_pkg::*;

	localparam logic [FILL_W-1:0] DEPTH_F = FILL_W'(CAPTURE_DEPTH);
	localparam logic [FILL_W-1:0] LAST_F  = FILL_W'(CAPTURE_DEPTH - 1);
	localparam int RAM_W = 2 * SAMPLE_BITS;
	localparam int X_LO  = 0;
	localparam int Y_LO  = 16;
	localparam int T_LO  = 32;
	localparam int C_BIT = 48;
	localparam int B_BIT = 49;
	localparam int I_LO  = 50;

	// configuration registers
	logic [FRAME_W-1:0]      frame_count_q;
	logic [TICK_W-1:0]       holdoff_q;
	logic                    lissajous_q;
	logic signed [SMP_W-1:0] trig_high_q;
	logic signed [SMP_W-1:0] trig_low_q;

	// capture state
	logic [FILL_W-1:0] fill_q;
	logic [TICK_W-1:0] tick_q;
	logic              trig_hi_q;
	logic              btn_hi_q;
	logic              ext_q;

	// pipeline
	logic              s1_valid;
	logic              s1_is_read;
	logic [FILL_W-1:0] s1_fill;
	logic              s1_ext;
	logic              s1_wait;
	logic              out_valid_q;
	logic [M_DATA_W-1:0] out_data_q;

	// input beat fields
	logic                    in_read;
	logic signed [SMP_W-1:0] in_x;
	logic signed [SMP_W-1:0] in_y;
	logic signed [SMP_W-1:0] in_trig;
	logic                    in_conn;
	logic                    in_btn;
	logic [IDX_W-1:0]        in_idx;

	assign in_read = (s_tuser == ACT_READ);
	assign in_x    = $signed(s_tdata[X_LO +: SMP_W]);
	assign in_y    = $signed(s_tdata[Y_LO +: SMP_W]);
	assign in_trig = $signed(s_tdata[T_LO +: SMP_W]);
	assign in_conn = s_tdata[C_BIT];
	assign in_btn  = s_tdata[B_BIT];
	assign in_idx  = s_tdata[I_LO +: IDX_W];

	// handshakes
	logic s1_adv;
	logic accept;
	assign s1_adv    = !out_valid_q || m_tready;
	assign s_tready  = !s1_valid || s1_adv;
	assign accept    = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;

	// configuration write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_count_q <= FRAME_COUNT_RST;
			holdoff_q     <= HOLDOFF_RST;
			lissajous_q   <= LISSAJOUS_RST;
			trig_high_q   <= TRIG_HIGH_RST;
			trig_low_q    <= TRIG_LOW_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_FRAME_COUNT: frame_count_q <= cfg_data[FRAME_W-1:0];
				REG_HOLDOFF:     holdoff_q     <= cfg_data[TICK_W-1:0];
				REG_LISSAJOUS:   lissajous_q   <= cfg_data[0];
				REG_TRIG_HIGH:   trig_high_q   <= $signed(cfg_data[SMP_W-1:0]);
				REG_TRIG_LOW:    trig_low_q    <= $signed(cfg_data[SMP_W-1:0]);
				default: ;
			endcase
		end
	end

	// sample tick: next-state logic for all scalar state
	logic              btn_hi_d;
	logic              ext_d;
	logic              was_full;
	logic [TICK_W-1:0] tick_inc;
	logic              do_store;
	logic [FILL_W-1:0] fill_cap;
	logic [TICK_W-1:0] tick_cap;
	logic              full_now;
	logic [TICK_W-1:0] tick_w;
	logic [TICK_W-1:0] tick_w1;
	logic              trig_start;
	logic signed [SMP_W-1:0] gate;
	logic              fired;
	logic              trig_d;
	logic [FILL_W-1:0] fill_d;
	logic [TICK_W-1:0] tick_d;

	always_comb begin
		// button Schmitt toggles external mode on a rising edge
		btn_hi_d = btn_hi_q;
		ext_d    = ext_q;
		if (btn_hi_q) begin
			if (!in_btn) begin
				btn_hi_d = 1'b0;
			end
		end else if (in_btn) begin
			btn_hi_d = 1'b1;
			ext_d    = !ext_q;
		end

		// decimated capture while not full
		was_full = (fill_q >= DEPTH_F);
		tick_inc = tick_q + TICK_W'(1);
		do_store = !was_full && (tick_inc > TICK_W'(frame_count_q));
		fill_cap = fill_q;
		tick_cap = tick_q;
		if (!was_full) begin
			if (do_store) begin
				fill_cap = fill_q + FILL_W'(1);
				tick_cap = '0;
			end else begin
				tick_cap = tick_inc;
			end
		end
		full_now = was_full || (do_store && (fill_q == LAST_F));

		// waiting for trigger; counter starts at zero on the filling tick
		tick_w     = was_full ? tick_q : '0;
		trig_start = (tick_w == '0) ? 1'b1 : trig_hi_q;
		tick_w1    = tick_w + TICK_W'(1);
		gate       = ext_d ? in_trig : in_x;
		fired      = 1'b0;
		trig_d     = trig_start;
		if (trig_start) begin
			if (gate <= trig_low_q) begin
				trig_d = 1'b0;
			end
		end else if (gate >= trig_high_q) begin
			trig_d = 1'b1;
			fired  = 1'b1;
		end

		// re-arm decision
		priority if (!full_now) begin
			fill_d = fill_cap;
			tick_d = tick_cap;
			trig_d = trig_hi_q;
		end else if (lissajous_q || (ext_d && !in_conn)) begin
			fill_d = '0;
			tick_d = '0;
			trig_d = trig_hi_q;
		end else if (fired || (tick_w1 >= holdoff_q)) begin
			fill_d = '0;
			tick_d = '0;
		end else begin
			fill_d = DEPTH_F;
			tick_d = tick_w1;
		end
	end

	// state update on sample ticks only
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q    <= '0;
			tick_q    <= '0;
			trig_hi_q <= 1'b1;
			btn_hi_q  <= 1'b1;
			ext_q     <= 1'b0;
		end else if (accept && !in_read) begin
			fill_q    <= fill_d;
			tick_q    <= tick_d;
			trig_hi_q <= trig_d;
			btn_hi_q  <= btn_hi_d;
			ext_q     <= ext_d;
		end
	end

	// read address: rotate by fill index in Lissajous mode, wrap to depth
	logic [FILL_W-1:0] idx_ext;
	logic [FILL_W-1:0] idx_mod;
	logic [FILL_W-1:0] idx_sum;
	logic [FILL_W-1:0] idx_rot;
	logic [IDX_W-1:0]  raddr;

	always_comb begin
		idx_ext = FILL_W'(in_idx);
		idx_mod = (idx_ext >= DEPTH_F) ? idx_ext - DEPTH_F : idx_ext;
		idx_sum = lissajous_q ? idx_mod + fill_q : idx_mod;
		idx_rot = (idx_sum >= DEPTH_F) ? idx_sum - DEPTH_F : idx_sum;
		raddr   = idx_rot[IDX_W-1:0];
	end

	// store data, sample width taken from the 16-bit voltage
	logic [31:0]        x_wide;
	logic [31:0]        y_wide;
	logic [RAM_W-1:0]   wdata;
	logic [RAM_W-1:0]   rdata;
	logic [31:0]        rx_wide;
	logic [31:0]        ry_wide;

	assign x_wide = {{(32 - SMP_W){in_x[SMP_W-1]}}, in_x};
	assign y_wide = {{(32 - SMP_W){in_y[SMP_W-1]}}, in_y};
	assign wdata  = {y_wide[SAMPLE_BITS-1:0], x_wide[SAMPLE_BITS-1:0]};
	assign rx_wide = {{(32 - SAMPLE_BITS){rdata[SAMPLE_BITS-1]}},
		rdata[SAMPLE_BITS-1:0]};
	assign ry_wide = {{(32 - SAMPLE_BITS){rdata[RAM_W-1]}},
		rdata[RAM_W-1:SAMPLE_BITS]};

	scap_ram #(
		.WIDTH (RAM_W),
		.DEPTH (CAPTURE_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (accept && !in_read && do_store),
		.waddr (fill_q[IDX_W-1:0]),
		.wdata (wdata),
		.re    (accept && in_read),
		.raddr (raddr),
		.rdata (rdata)
	);

	// stage 1: status fields while the RAM read completes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid <= 1'b0;
		end else if (s_tready) begin
			s1_valid <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			s1_is_read <= in_read;
			s1_fill    <= in_read ? fill_q : fill_d;
			s1_ext     <= in_read ? ext_q : ext_d;
			s1_wait    <= in_read ? was_full : (fill_d >= DEPTH_F);
		end
	end

	// output register
	logic [SMP_W-1:0] res_x;
	logic [SMP_W-1:0] res_y;
	assign res_x = s1_is_read ? rx_wide[SMP_W-1:0] : '0;
	assign res_y = s1_is_read ? ry_wide[SMP_W-1:0] : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_adv) begin
			out_valid_q <= s1_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv && s1_valid) begin
			out_data_q <= M_DATA_W'({s1_wait, s1_ext, s1_fill, res_y, res_x});
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

endmodule

`default_nettype wire
